FILE: hw/rtl/vpo_osc_pkg.sv
// package for the volt-per-octave sine oscillator: constants and table builders
`default_nettype none

package vpo_osc_pkg;

    localparam int MV_PER_OCTAVE = 1000;

    localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] AMPLITUDE  = 64'd32000;
    localparam logic [63:0] SINE_LIMIT = 64'd32767;
    localparam logic [63:0] INC_BASE   = ((64'd1 << 36) * 64'd11) / 64'd1200;

    localparam int SERIES_TERMS = 20;

    // divisors of the sine series, (2n)(2n+1)
    localparam logic [63:0] SIN_DIV [SERIES_TERMS] = '{
        64'd6,    64'd20,   64'd42,   64'd72,   64'd110,
        64'd156,  64'd210,  64'd272,  64'd342,  64'd420,
        64'd506,  64'd600,  64'd702,  64'd812,  64'd930,
        64'd1056, 64'd1190, 64'd1332, 64'd1482, 64'd1640
    };

    // divisors of the exponential series, n
    localparam logic [63:0] EXP_DIV [SERIES_TERMS] = '{
        64'd1,  64'd2,  64'd3,  64'd4,  64'd5,
        64'd6,  64'd7,  64'd8,  64'd9,  64'd10,
        64'd11, 64'd12, 64'd13, 64'd14, 64'd15,
        64'd16, 64'd17, 64'd18, 64'd19, 64'd20
    };

    // sine magnitude for an angle in q28, scaled to the output amplitude
    function automatic logic [15:0] sine_magnitude(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x2   = (x * x) >> 28;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = ((term * x2) >> 28) / SIN_DIV[n-1];
            if (n[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        scaled = ($unsigned(sum) * AMPLITUDE) >> 28;
        if (scaled > SINE_LIMIT)
        begin
            scaled = SINE_LIMIT;
        end
        return scaled[15:0];
    endfunction

    // phase increment for an exponent argument in q30
    function automatic logic [31:0] increment_value(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] prod;
        term = 64'd1 << 30;
        sum  = term;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = ((term * x) >> 30) / EXP_DIV[n-1];
            sum  = sum + term;
        end
        prod = (INC_BASE * sum) >> 34;
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/volt_per_octave_sine_oscillator_top.sv
// volt-per-octave sine oscillator: pitch word in, interpolated sine word out
//
// input channel: pitch_valid / pitch_stall carry pitch_millivolts, signed
// millivolts with 0 at a4 and 1000 per octave. output channel: sample_valid /
// sample_stall carry sine_sample, a signed sample of about +-2000.
// a word is taken on a rising edge with valid high and stall low.
// each pitch word advances a 32-bit phase by an exponential increment and
// returns one sample read from the sine table and linearly interpolated.
// throughput: one word per cycle while the receiver does not stall. the
// pipeline has eight stages (input register, split octave divide, registered
// increment table read, phase add, index multiply, registered sine table
// reads, interpolation multiply into the output register).
// stages hold their words while the receiver stalls; empty stages still fill,
// so pitch_stall rises only when the output word is held and every stage is
// full. reset clears the phase to zero and empties the pipeline.
`default_nettype none

module volt_per_octave_sine_oscillator_top #(
    parameter int SINE_ENTRIES     = 512,
    parameter int STEPS_PER_OCTAVE = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pitch_valid,
    output logic               pitch_stall,
    input  logic signed [13:0] pitch_millivolts,
    output logic               sample_valid,
    input  logic               sample_stall,
    output logic signed [11:0] sine_sample
);
    import vpo_osc_pkg::*;

    localparam int STAGES = 8;
    localparam int AW     = $clog2(SINE_ENTRIES);
    localparam int PW     = 32 + AW;

    localparam logic [14:0] MV_OFFSET   = 15'd9000;
    localparam logic [12:0] RECIP_1000  = 13'd4194;
    localparam logic [14:0] MV_OCT_W    = 15'd1000;
    localparam logic [4:0]  OCT_LOW     = 5'd3;
    localparam logic [4:0]  OCT_HIGH    = 5'd14;
    localparam logic [3:0]  OCT_CENTER  = 4'd9;

    // constant tables built at elaboration
    logic [31:0]        inc_table  [MV_PER_OCTAVE];
    logic signed [15:0] sine_table [SINE_ENTRIES];

    for (genvar g = 0; g < MV_PER_OCTAVE; g++)
    begin : g_inc_table
        localparam logic [63:0] STEP = 64'(g) * 64'(STEPS_PER_OCTAVE) / MV_PER_OCTAVE;
        localparam logic [63:0] XQ   = STEP * LN2_Q30 / STEPS_PER_OCTAVE;
        assign inc_table[g] = increment_value(XQ);
    end

    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_sine_table
        localparam bit          NEG = (2 * g > SINE_ENTRIES);
        localparam logic [63:0] KQ  = NEG ? 64'(SINE_ENTRIES - g) : 64'(g);
        localparam logic [63:0] XQ  = KQ * TWO_PI_Q28 / SINE_ENTRIES;
        localparam logic [15:0] MAG = sine_magnitude(XQ);
        assign sine_table[g] = NEG ? $signed(~MAG + 16'd1) : $signed(MAG);
    end

    // pipeline control
    logic [STAGES-1:0] stage_valid_reg;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] valid_in;
    logic [STAGES-1:0] load;

    always_comb
    begin
        stage_ready[STAGES-1] = !stage_valid_reg[STAGES-1] || !sample_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k+1];
        end
    end

    assign valid_in     = {stage_valid_reg[STAGES-2:0], pitch_valid};
    assign load         = stage_ready & valid_in;
    assign pitch_stall  = !stage_ready[0];
    assign sample_valid = stage_valid_reg[STAGES-1];

    // stage registers
    logic signed [13:0]  mv_reg;
    logic [14:0]         u_reg;
    logic [4:0]          qest_reg;
    logic [9:0]          rem_reg;
    logic [3:0]          oct_reg;
    logic [31:0]         inc_reg;
    logic [3:0]          oct_inc_reg;
    logic [31:0]         phase_reg;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       nxt_reg;
    logic [15:0]         frac_reg;
    logic signed [15:0]  s1_reg;
    logic signed [15:0]  s2_reg;
    logic [15:0]         frac_rd_reg;
    logic signed [11:0]  sine_sample_reg;

    // octave split: floor divide by 1000 via reciprocal
    logic [14:0] u_next;
    logic [27:0] div_prod;
    logic [4:0]  qest_next;

    assign u_next    = $unsigned($signed({mv_reg[13], mv_reg}) + $signed(MV_OFFSET));
    assign div_prod  = u_next * RECIP_1000;
    assign qest_next = div_prod[26:22];

    // correction and octave clamp
    logic [14:0] qest_scaled;
    logic [14:0] rem_raw;
    logic [4:0]  q_fix;
    logic [9:0]  rem_next;
    logic [3:0]  oct_next;

    assign qest_scaled = 15'(qest_reg) * MV_OCT_W;
    assign rem_raw     = u_reg - qest_scaled;

    always_comb
    begin
        if (rem_raw >= MV_OCT_W)
        begin
            rem_next = 10'(rem_raw - MV_OCT_W);
            q_fix    = qest_reg + 5'd1;
        end
        else
        begin
            rem_next = 10'(rem_raw);
            q_fix    = qest_reg;
        end
        priority if (q_fix < OCT_LOW)
        begin
            oct_next = 4'(OCT_LOW);
        end
        else if (q_fix > OCT_HIGH)
        begin
            oct_next = 4'(OCT_HIGH);
        end
        else
        begin
            oct_next = 4'(q_fix);
        end
    end

    // octave shift and phase accumulate
    logic [31:0] inc_shifted;
    logic [31:0] phase_next;

    always_comb
    begin
        if (oct_inc_reg >= OCT_CENTER)
        begin
            inc_shifted = inc_reg << 3'(oct_inc_reg - OCT_CENTER);
        end
        else
        begin
            inc_shifted = inc_reg >> 3'(OCT_CENTER - oct_inc_reg);
        end
    end

    assign phase_next = phase_reg + inc_shifted;

    // sine table index and fraction
    logic [PW-1:0] phase_scaled;
    logic [AW-1:0] idx_next;
    logic [AW-1:0] nxt_next;

    assign phase_scaled = {{AW{1'b0}}, phase_reg} * PW'(SINE_ENTRIES);
    assign idx_next     = phase_scaled[PW-1:32];
    assign nxt_next     = (idx_next == AW'(SINE_ENTRIES - 1)) ? '0 : idx_next + 1'b1;

    // interpolation
    logic signed [16:0] diff;
    logic signed [33:0] weighted;
    logic signed [33:0] interp;

    assign diff     = 17'(s2_reg) - 17'(s1_reg);
    assign weighted = diff * $signed({1'b0, frac_rd_reg});
    assign interp   = 34'($signed({s1_reg, 16'h0000})) + weighted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    stage_valid_reg[k] <= valid_in[k];
                end
            end
            if (load[4])
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            mv_reg <= pitch_millivolts;
        end
        if (load[1])
        begin
            u_reg    <= u_next;
            qest_reg <= qest_next;
        end
        if (load[2])
        begin
            rem_reg <= rem_next;
            oct_reg <= oct_next;
        end
        if (load[3])
        begin
            inc_reg     <= inc_table[rem_reg];
            oct_inc_reg <= oct_reg;
        end
        if (load[5])
        begin
            idx_reg  <= idx_next;
            nxt_reg  <= nxt_next;
            frac_reg <= phase_scaled[31:16];
        end
        if (load[6])
        begin
            s1_reg      <= sine_table[idx_reg];
            s2_reg      <= sine_table[nxt_reg];
            frac_rd_reg <= frac_reg;
        end
        if (load[7])
        begin
            sine_sample_reg <= $signed(interp[31:20]);
        end
    end

    assign sine_sample = sine_sample_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vpo_osc_checker.sv
// port checker for the volt-per-octave sine oscillator, bound to the top level
`default_nettype none

module vpo_osc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pitch_stall,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic signed [11:0] sine_sample
);

    // a held output word keeps its value
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sine_sample))
        else $error("output word changed while stalled");

    // input backs up only when the output word is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        pitch_stall |-> sample_valid && sample_stall)
        else $error("input stalled with output free");

    // interpolated sample stays inside the table amplitude
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> (sine_sample >= -12'sd2000) && (sine_sample <= 12'sd2000))
        else $error("sample out of range");

endmodule

bind volt_per_octave_sine_oscillator_top vpo_osc_checker u_vpo_osc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pitch_stall  (pitch_stall),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sine_sample  (sine_sample)
);

`default_nettype wire

FILE: test/tb_volt_per_octave_sine_oscillator_top.sv
// testbench for the volt-per-octave sine oscillator: predicts every sample and checks it
`timescale 1ns / 100ps

module tb_volt_per_octave_sine_oscillator_top;

    localparam int SINE_ENTRIES     = 512;
    localparam int STEPS_PER_OCTAVE = 1000;
    localparam int MV_PER_OCTAVE    = 1000;
    localparam int OCTAVE_LOW       = -6;
    localparam int OCTAVE_HIGH      = 5;
    localparam int RANDOM_WORDS     = 1650;
    localparam int DRAIN_CYCLES     = 16;

    localparam logic [63:0] TWO_PI_Q28  = 64'd1686629713;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] SINE_AMPL   = 64'd32000;
    localparam logic [63:0] SINE_CLAMP  = 64'd32767;
    localparam logic [63:0] STEP_BASE   = ((64'd1 << 36) * 64'd11) / 64'd1200;

    localparam logic signed [13:0] EDGE_PITCHES [23] = '{
        0, 1, -1, 999, 1000, -999, -1000, -1001, 4999, 5000, 5999, 6000,
        -5999, -6000, -6001, 7999, -7001, 8191, -8192, 5461, -5462, 2730, -2731
    };

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

    class osc_scoreboard_t;
        logic signed [15:0] sine_table [SINE_ENTRIES];
        logic [31:0]        step_table [STEPS_PER_OCTAVE];
        logic [31:0]        phase;
        logic signed [11:0] expected_samples [$];
        int                 errors;
        int                 words;
        int                 clamped;
        int                 compared;

        function new();
            for (int i = 0; i < SINE_ENTRIES; i++)
            begin
                sine_table[i] = sine_value(i);
            end
            for (int i = 0; i < STEPS_PER_OCTAVE; i++)
            begin
                step_table[i] = step_value(i);
            end
            phase    = '0;
            errors   = 0;
            words    = 0;
            clamped  = 0;
            compared = 0;
        endfunction

        function logic signed [15:0] sine_value(int i);
            logic [63:0]        k;
            logic [63:0]        x;
            logic [63:0]        x2;
            logic [63:0]        term;
            logic [63:0]        scaled;
            longint             acc;
            logic               flip;
            logic signed [15:0] mag;
            k    = 64'(i);
            flip = 1'b0;
            if (2 * k > 64'(SINE_ENTRIES))
            begin
                k    = 64'(SINE_ENTRIES) - k;
                flip = 1'b1;
            end
            x    = k * TWO_PI_Q28 / 64'(SINE_ENTRIES);
            x2   = (x * x) >> 28;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 20; n++)
            begin
                term = ((term * x2) >> 28) / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            scaled = acc;
            scaled = (scaled * SINE_AMPL) >> 28;
            if (scaled > SINE_CLAMP)
            begin
                scaled = SINE_CLAMP;
            end
            mag = scaled[15:0];
            return flip ? -mag : mag;
        endfunction

        function logic [31:0] step_value(int i);
            logic [63:0] x;
            logic [63:0] term;
            logic [63:0] acc;
            logic [63:0] prod;
            x    = 64'(i) * LN2_Q30 / 64'(STEPS_PER_OCTAVE);
            term = 64'd1 << 30;
            acc  = term;
            for (int n = 1; n <= 20; n++)
            begin
                term = ((term * x) >> 30) / 64'(n);
                acc  = acc + term;
            end
            prod = (STEP_BASE * acc) >> 34;
            return prod[31:0];
        endfunction

        function logic signed [11:0] predict_sample(logic signed [13:0] mv);
            int                 volts;
            int                 octave;
            int                 rem;
            int                 idx;
            int                 ent;
            int                 nxt;
            logic [31:0]        step;
            logic [63:0]        p;
            logic [15:0]        fr;
            longint             s1;
            longint             s2;
            longint             acc;
            logic signed [11:0] sample;
            volts  = mv;
            octave = volts / MV_PER_OCTAVE;
            rem    = volts % MV_PER_OCTAVE;
            if (rem < 0)
            begin
                rem    = rem + MV_PER_OCTAVE;
                octave = octave - 1;
            end
            if (octave < OCTAVE_LOW || octave > OCTAVE_HIGH)
            begin
                clamped++;
            end
            if (octave < OCTAVE_LOW)
            begin
                octave = OCTAVE_LOW;
            end
            if (octave > OCTAVE_HIGH)
            begin
                octave = OCTAVE_HIGH;
            end
            idx = rem * STEPS_PER_OCTAVE / MV_PER_OCTAVE;
            if (idx >= STEPS_PER_OCTAVE)
            begin
                idx = STEPS_PER_OCTAVE - 1;
            end
            step = step_table[idx];
            if (octave >= 0)
            begin
                step = step << octave;
            end
            else
            begin
                step = step >> (-octave);
            end
            phase = phase + step;
            p     = {32'd0, phase} * 64'(SINE_ENTRIES);
            ent   = int'(p[63:32]);
            if (ent >= SINE_ENTRIES)
            begin
                ent = SINE_ENTRIES - 1;
            end
            fr  = p[31:16];
            nxt = (ent + 1 >= SINE_ENTRIES) ? 0 : ent + 1;
            s1  = sine_table[ent];
            s2  = sine_table[nxt];
            acc = s2 * longint'(fr) + s1 * (64'sd65536 - longint'(fr));
            sample = acc >>> 20;
            return sample;
        endfunction

        function void note_pitch(logic signed [13:0] mv);
            words++;
            expected_samples.push_back(predict_sample(mv));
        endfunction

        function void check_sample(logic signed [11:0] got);
            logic signed [11:0] want;
            if (expected_samples.size() == 0)
            begin
                $error("sine_sample with nothing expected: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            compared++;
            if (got !== want)
            begin
                $error("sine_sample mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk              = 1'b0;
    logic               rst_n            = 1'b0;
    logic               pitch_valid      = 1'b0;
    logic               pitch_stall;
    logic signed [13:0] pitch_millivolts = '0;
    logic               sample_valid;
    logic               sample_stall     = 1'b0;
    logic signed [11:0] sine_sample;

    stall_pattern_t  stall_pattern = STALL_NONE;
    int              stall_left    = 0;
    osc_scoreboard_t books         = new();

    volt_per_octave_sine_oscillator_top #(
        .SINE_ENTRIES    (SINE_ENTRIES),
        .STEPS_PER_OCTAVE(STEPS_PER_OCTAVE)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .pitch_valid     (pitch_valid),
        .pitch_stall     (pitch_stall),
        .pitch_millivolts(pitch_millivolts),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sine_sample     (sine_sample)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_pattern <= stall_pattern_t'($urandom_range(0, 3));
            stall_left    <= $urandom_range(32, 256);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        unique case (stall_pattern)
            STALL_NONE:     sample_stall <= 1'b0;
            STALL_LIGHT:    sample_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:    sample_stall <= ($urandom_range(0, 9) < 8);
            STALL_PERIODIC: sample_stall <= (stall_left % 5 < 2);
            default:        sample_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            books.check_sample(sine_sample);
        end
    end

    task automatic send_pitch(input logic signed [13:0] mv);
        pitch_valid      <= 1'b1;
        pitch_millivolts <= mv;
        @(posedge clk);
        while (pitch_stall)
        begin
            @(posedge clk);
        end
        books.note_pitch(mv);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        pitch_valid <= 1'b0;
        while (books.pending() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic signed [13:0] random_pitch();
        int unsigned pick;
        int          octv;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            return 14'(int'($urandom_range(0, 12000)) - 6000);
        end
        else if (pick < 90)
        begin
            return 14'($urandom);
        end
        octv = int'($urandom_range(0, 14)) - 7;
        return 14'(octv * MV_PER_OCTAVE + int'($urandom_range(0, 2)) - 1);
    endfunction

    initial
    begin
        int sent;
        int burst;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (EDGE_PITCHES[i])
        begin
            send_pitch(EDGE_PITCHES[i]);
        end
        wait_for_drain();

        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 48);
            for (int j = 0; j < burst && sent < RANDOM_WORDS; j++)
            begin
                send_pitch(random_pitch());
                sent++;
            end
            if (!paused && sent > RANDOM_WORDS / 2)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                pitch_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        pitch_valid <= 1'b0;

        while (books.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pitch words (%0d beyond the octave clamp), %0d samples compared",
                 books.words, books.clamped, books.compared);
        if (books.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
